// ----- src/ookpd_pkg.sv -----
package ookpd_pkg;

  // Number of button codes that select a table entry; higher indexes give code zero.
  localparam int CODE_COUNT = 32;
  localparam int ROM_DEPTH  = 32;

  // Stream layout constants.
  localparam int        PRE_BYTES   = 3;
  localparam int        FRAME_PAIRS = 16;
  localparam logic [7:0] PRE_ONES   = 8'hFF;
  localparam logic [7:0] PRE_ZEROS  = 8'h00;
  localparam logic [7:0] MARK_CHIP  = 8'h80;
  localparam logic [3:0] TRAIL_LEN  = 4'd4;
  localparam logic [3:0] BYTE_CHIPS = 4'd8;

  typedef struct packed {
    logic [7:0] pin;
    logic [5:0] key_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] chip_byte;
    logic [3:0] valid_chips;
    logic       last;
  } out_item_t;

  // Control from the sequencer into the chip packer.
  typedef struct packed {
    logic       adv;
    logic       clr;
    logic [7:0] sym;
    logic [3:0] len;
  } pk_ctrl_t;

  localparam logic [7:0] CODE_ROM [ROM_DEPTH] = '{
    8'h32, 8'h78, 8'h70, 8'h60, 8'hCA, 8'h20, 8'hF2, 8'hA0,
    8'h84, 8'h44, 8'hC4, 8'h30, 8'h80, 8'hB0, 8'hF0, 8'h08,
    8'h88, 8'h48, 8'hC8, 8'h28, 8'hA8, 8'h68, 8'hE8, 8'h18,
    8'h98, 8'h58, 8'hD0, 8'h90, 8'hC0, 8'h50, 8'h10, 8'h40
  };

  // Button code lookup; indexes outside the table give code zero.
  function automatic logic [7:0] code_lookup(input logic [5:0] idx);
    logic [7:0] code;
    code = 8'h00;
    if ((int'(idx) < CODE_COUNT) && (int'(idx) < ROM_DEPTH)) begin
      code = CODE_ROM[idx[4:0]];
    end
    return code;
  endfunction

endpackage

// ----- src/ook_pulse_distance_frame_encoder_unit.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_item  (pin, key_index)
// out       output     out_valid/ out_stall out_item (chip_byte, valid_chips, last)
// cfg       input      cfg_wr_en            cfg_wr_data (sync word)
//
// An item passes through three preamble steps, sixteen steps of two frame
// bits each, a trailer step and sometimes a flush step.
// The chip packer adds a symbol of up to eight chips per cycle unless stalled.
// The sequencer advances only when the output register can take a byte.
// Reset clears the sequencer, the output valid and the sync word to zero.
module ook_pulse_distance_frame_encoder_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ookpd_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ookpd_pkg::out_item_t out_item,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_PRE, ST_FRAME, ST_TRAIL, ST_FLUSH} state_t;

  localparam logic [3:0] PRE_LAST   = 4'(ookpd_pkg::PRE_BYTES - 1);
  localparam logic [3:0] FRAME_LAST = 4'(ookpd_pkg::FRAME_PAIRS - 1);

  state_t     state;
  logic [3:0] step;
  logic [31:0] frame;
  logic [7:0] sync_word;

  ookpd_pkg::pk_ctrl_t ctrl;
  logic [7:0] head_byte;
  logic [4:0] comb_cnt;
  logic       out_free;
  logic       accept;
  logic [7:0] pin_rev;
  logic [7:0] code;
  logic [3:0] len_hi;
  logic       emit;
  logic       emit_last;
  logic [3:0] emit_cnt;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Sync word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= '0;
    end else if (cfg_wr_en) begin
      sync_word <= cfg_wr_data;
    end
  end

  // Frame fields: the PIN goes out least significant bit first.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pin_rev[i] = in_item.pin[7 - i];
    end
    code = ookpd_pkg::code_lookup(in_item.key_index);
  end

  // Symbol selection and byte emission for the current step.
  always_comb begin
    ctrl      = '0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_cnt  = ookpd_pkg::BYTE_CHIPS;
    len_hi    = frame[31] ? 4'd4 : 4'd2;
    case (state)
      ST_PRE: begin
        ctrl.sym = (step == PRE_LAST) ? ookpd_pkg::PRE_ZEROS : ookpd_pkg::PRE_ONES;
        ctrl.len = ookpd_pkg::BYTE_CHIPS;
        emit     = 1'b1;
      end
      ST_FRAME: begin
        // Both a one and a zero start with a mark; only their lengths differ.
        ctrl.sym = ookpd_pkg::MARK_CHIP | (ookpd_pkg::MARK_CHIP >> len_hi);
        ctrl.len = len_hi + (frame[30] ? 4'd4 : 4'd2);
        emit     = (comb_cnt >= 5'd8);
      end
      ST_TRAIL: begin
        ctrl.sym = ookpd_pkg::MARK_CHIP;
        ctrl.len = ookpd_pkg::TRAIL_LEN;
        emit     = 1'b1;
        if (comb_cnt <= 5'd8) begin
          emit_last = 1'b1;
          emit_cnt  = comb_cnt[3:0];
          ctrl.clr  = 1'b1;
        end
      end
      ST_FLUSH: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_cnt  = comb_cnt[3:0];
        ctrl.clr  = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
    ctrl.adv = out_free && (state != ST_IDLE);
  end

  ookpd_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .head_byte (head_byte),
    .comb_cnt  (comb_cnt)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid            <= emit && (state != ST_IDLE);
        out_item.chip_byte   <= head_byte;
        out_item.valid_chips <= emit_cnt;
        out_item.last        <= emit_last;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            frame <= {sync_word, pin_rev, code, ~code};
            step  <= '0;
            state <= ST_PRE;
          end
        end
        ST_PRE: begin
          if (out_free) begin
            if (step == PRE_LAST) begin
              step  <= '0;
              state <= ST_FRAME;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        ST_FRAME: begin
          if (out_free) begin
            frame <= {frame[29:0], 2'b00};
            if (step == FRAME_LAST) begin
              step  <= '0;
              state <= ST_TRAIL;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        ST_TRAIL: begin
          if (out_free) begin
            state <= emit_last ? ST_IDLE : ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/ookpd_packer.sv -----
module ookpd_packer (
  input  logic              clk,
  input  logic              rst,
  input  ookpd_pkg::pk_ctrl_t ctrl,
  output logic [7:0]        head_byte,
  output logic [4:0]        comb_cnt
);

  // Left-aligned chip window and its fill level (always below eight between steps).
  logic [15:0] win;
  logic [4:0]  cnt;
  logic [15:0] comb;

  // Append the symbol right behind the chips already held.
  always_comb begin
    comb      = win | ({ctrl.sym, 8'h00} >> cnt);
    comb_cnt  = cnt + {1'b0, ctrl.len};
    head_byte = comb[15:8];
  end

  // On an advance, a full byte leaves the window whenever eight or more chips are present; a clear empties it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      win <= '0;
    end else if (ctrl.adv) begin
      if (ctrl.clr) begin
        cnt <= '0;
        win <= '0;
      end else if (comb_cnt >= 5'd8) begin
        cnt <= comb_cnt - 5'd8;
        win <= {comb[7:0], 8'h00};
      end else begin
        cnt <= comb_cnt;
        win <= comb;
      end
    end
  end

endmodule
